### hw/rtl/acmu_pkg.sv
// Shared types, codes and condition evaluation for the conditional multiply unit.
package acmu_pkg;

	localparam int unsigned NUM_REGS = 16;
	localparam int unsigned REG_AW   = $clog2(NUM_REGS);
	localparam int unsigned DATA_W   = 32;

	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE         = 3'd0,
		ST_COND_FAIL    = 3'd1,
		ST_BAD_COND     = 3'd2,
		ST_NOT_MODELLED = 3'd3,
		ST_BAD_CLASS    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CR_FAIL = 2'd0,
		CR_PASS = 2'd1,
		CR_BAD  = 2'd2
	} cond_res_t;

	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	// Instruction field positions.
	localparam int unsigned BIT_A = 21;
	localparam int unsigned BIT_S = 20;

	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	// Outcome of one item in the execute stage.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t           status;
		logic [3:0]        flags;
		logic              wr_en;
		logic [REG_AW-1:0] wr_addr;
	} exec_res_t;

	function automatic cond_res_t cond_eval(input logic [3:0] cond, input logic [3:0] f);
		logic n;
		logic z;
		logic v;
		cond_res_t r;
		n = f[FLAG_N];
		z = f[FLAG_Z];
		v = f[FLAG_V];
		unique case (cond)
			COND_EQ: r = z ? CR_PASS : CR_FAIL;
			COND_NE: r = !z ? CR_PASS : CR_FAIL;
			COND_GE: r = (n == v) ? CR_PASS : CR_FAIL;
			COND_LT: r = (n != v) ? CR_PASS : CR_FAIL;
			COND_GT: r = (!z && (n == v)) ? CR_PASS : CR_FAIL;
			COND_LE: r = (z || (n != v)) ? CR_PASS : CR_FAIL;
			COND_AL: r = CR_PASS;
			default: r = CR_BAD;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/acmu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module acmu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/acmu_exec.sv
// Execute stage: condition check, instruction decode and multiply-accumulate, plus register write and read commands.
module acmu_exec (
	input  acmu_pkg::cmd_t                      cmd,
	input  logic [31:0]                         instr,
	input  logic [acmu_pkg::REG_AW-1:0]         sel,
	input  logic [acmu_pkg::DATA_W-1:0]         wval,
	input  logic [acmu_pkg::DATA_W-1:0]         op_m,
	input  logic [acmu_pkg::DATA_W-1:0]         op_s,
	input  logic [acmu_pkg::DATA_W-1:0]         op_n,
	input  logic [3:0]                          flags,
	output acmu_pkg::exec_res_t                 res,
	output logic [acmu_pkg::DATA_W-1:0]         wr_data
);
	import acmu_pkg::*;

	cond_res_t         cr;
	logic              is_mul;
	logic [DATA_W-1:0] product;
	logic [DATA_W-1:0] mac;

	assign cr      = cond_eval(instr[31:28], flags);
	assign is_mul  = (instr[27:25] == 3'b000) && instr[7] && instr[4];
	// Only the low word of the product is kept, so the narrow multiply suffices.
	assign product = op_m * op_s;
	assign mac     = instr[BIT_A] ? (product + op_n) : product;

	always_comb begin
		res.value   = '0;
		res.status  = ST_DONE;
		res.flags   = flags;
		res.wr_en   = 1'b0;
		res.wr_addr = sel;
		wr_data     = wval;
		unique case (cmd)
			CMD_WRITE: begin
				res.value = wval;
				res.wr_en = 1'b1;
			end
			CMD_READ: begin
				res.value = op_m;
			end
			CMD_NONE: begin
				res.status = ST_BAD_CLASS;
			end
			default: begin
				if (cr == CR_BAD) begin
					res.status = ST_BAD_COND;
				end else if (cr == CR_FAIL) begin
					res.status = ST_COND_FAIL;
				end else if (instr[27:26] == 2'b11) begin
					res.status = ST_BAD_CLASS;
				end else if (!is_mul) begin
					res.status = ST_NOT_MODELLED;
				end else begin
					res.value   = mac;
					res.wr_en   = 1'b1;
					res.wr_addr = instr[19:16];
					wr_data     = mac;
					if (instr[BIT_S]) begin
						res.flags[FLAG_N] = mac[DATA_W-1];
						res.flags[FLAG_Z] = (mac == '0);
					end
				end
			end
		endcase
	end

endmodule

### hw/rtl/arm_conditional_multiply_unit.sv
// Top level of the conditional multiply unit: register file, pipeline and output register.
//
// Usage. The input channel (in_valid / in_ready) carries one command per item:
// execute an instruction word, write a register, or read a register. The output
// channel (out_valid / out_ready) returns exactly one item per command, in order,
// with read_value, status and the NZCV flags after the command.
// An accepted item is registered into the execute stage and from there into the output
// register. Throughput is one item per cycle while the receiver takes results; the figure is
// set by the single read-modify-write pass over the register file, whose operands
// come from three copies of a synchronous RAM with forwarding of the previous write,
// and by the combinational multiply-add.
// When the receiver stalls, the result waits in the output register and one more
// item may sit in the execute stage; in_ready drops only when both are occupied.
// Reset clears the flags, the pipeline and the per-register valid bits, so every
// register reads as zero until written; no clearing pass is needed.
module arm_conditional_multiply_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [31:0]                 instruction_word,
	input  logic [3:0]                  reg_select,
	input  logic [31:0]                 write_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 read_value,
	output logic [2:0]                  status,
	output logic [3:0]                  flags_nzcv
);
	import acmu_pkg::*;

	logic              in_fire;
	logic              s1_adv;
	logic              s1_valid_q;
	cmd_t              cmd_s1;
	logic [31:0]       instr_s1;
	logic [REG_AW-1:0] sel_s1;
	logic [DATA_W-1:0] wval_s1;

	logic [REG_AW-1:0] raddr_m;
	logic [DATA_W-1:0] rdata_m;
	logic [DATA_W-1:0] rdata_s;
	logic [DATA_W-1:0] rdata_n;
	logic [DATA_W-1:0] op_m;
	logic [DATA_W-1:0] op_s;
	logic [DATA_W-1:0] op_n;
	logic [REG_AW-1:0] addr_m_s1;

	logic [NUM_REGS-1:0] rf_valid_q;
	logic                lw_valid_q;
	logic [REG_AW-1:0]   lw_addr_q;
	logic [DATA_W-1:0]   lw_data_q;

	logic [3:0]        flags_q;
	exec_res_t         ex;
	logic [DATA_W-1:0] ex_wdata;
	logic              rf_we;

	logic              out_valid_q;
	logic [DATA_W-1:0] read_value_q;
	status_t           status_q;
	logic [3:0]        flags_out_q;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign rf_we    = s1_adv && ex.wr_en;

	// Port m serves Rm for execute and the selected register for a read.
	assign raddr_m = (cmd == CMD_EXEC) ? instruction_word[3:0] : reg_select;

	acmu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_m (
		.clk(clk), .we(rf_we), .waddr(ex.wr_addr), .wdata(ex_wdata),
		.re(in_fire), .raddr(raddr_m), .rdata(rdata_m)
	);

	acmu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_s (
		.clk(clk), .we(rf_we), .waddr(ex.wr_addr), .wdata(ex_wdata),
		.re(in_fire), .raddr(instruction_word[11:8]), .rdata(rdata_s)
	);

	acmu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_n (
		.clk(clk), .we(rf_we), .waddr(ex.wr_addr), .wdata(ex_wdata),
		.re(in_fire), .raddr(instruction_word[15:12]), .rdata(rdata_n)
	);

	// The RAM may have missed a write made on the edge the item entered the stage,
	// so the latest write is forwarded; an entry never written reads as zero.
	function automatic logic [DATA_W-1:0] operand(
		input logic [REG_AW-1:0] addr,
		input logic [DATA_W-1:0] ram_data,
		input logic [NUM_REGS-1:0] vld,
		input logic lw_v,
		input logic [REG_AW-1:0] lw_a,
		input logic [DATA_W-1:0] lw_d
	);
		logic [DATA_W-1:0] r;
		if (lw_v && (lw_a == addr)) begin
			r = lw_d;
		end else if (vld[addr]) begin
			r = ram_data;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	assign addr_m_s1 = (cmd_s1 == CMD_EXEC) ? instr_s1[3:0] : sel_s1;
	assign op_m = operand(addr_m_s1, rdata_m, rf_valid_q, lw_valid_q, lw_addr_q, lw_data_q);
	assign op_s = operand(instr_s1[11:8], rdata_s, rf_valid_q, lw_valid_q, lw_addr_q,
		lw_data_q);
	assign op_n = operand(instr_s1[15:12], rdata_n, rf_valid_q, lw_valid_q, lw_addr_q,
		lw_data_q);

	acmu_exec u_exec (
		.cmd(cmd_s1), .instr(instr_s1), .sel(sel_s1), .wval(wval_s1),
		.op_m(op_m), .op_s(op_s), .op_n(op_n), .flags(flags_q),
		.res(ex), .wr_data(ex_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			rf_valid_q  <= '0;
			lw_valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				flags_q     <= ex.flags;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rf_we) begin
				rf_valid_q[ex.wr_addr] <= 1'b1;
				lw_valid_q             <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1   <= cmd_t'(cmd);
			instr_s1 <= instruction_word;
			sel_s1   <= reg_select;
			wval_s1  <= write_value;
		end
		if (rf_we) begin
			lw_addr_q <= ex.wr_addr;
			lw_data_q <= ex_wdata;
		end
		if (s1_adv) begin
			read_value_q <= ex.value;
			status_q     <= ex.status;
			flags_out_q  <= ex.flags;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign flags_nzcv = flags_out_q;

`ifndef SYNTHESIS
	a_write_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (s1_valid_q && (!out_valid_q || out_ready)))
		else $error("register file written without the item moving on");

	a_flags_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(flags_q))
		else $error("flags changed without a completing item");

	a_value_zero_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_DONE)) |-> (read_value == '0))
		else $error("nonzero result value on a failed item");

	a_out_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flags_nzcv == flags_q))
		else $error("reported flags differ from the flag register");
`endif

endmodule
